// File: hdl/kvs_pkg.sv
// Shared types and constants for the keyframe vec3 sampler.
// No dependencies; used by kvs_key_store and keyframe_vec3_sampler.
`timescale 1ns / 1ps

package kvs_pkg;

   localparam int MAX_KEYS = 256;
   localparam int KEY_AW   = $clog2(MAX_KEYS);
   localparam int CNT_W    = KEY_AW + 1;

   localparam logic [0:0]  OP_LOAD   = 1'b0;
   localparam logic [0:0]  OP_SAMPLE = 1'b1;

   localparam logic [1:0]  REG_KEY_COUNT = 2'd0;
   localparam logic [1:0]  REG_DURATION  = 2'd1;
   localparam logic [1:0]  REG_MODE      = 2'd2;

   localparam logic [1:0]  MODE_LINEAR = 2'd0;
   localparam logic [1:0]  MODE_STEP   = 2'd1;

   localparam logic [16:0] FACTOR_ONE = 17'h10000;

   typedef logic [2:0][31:0] vec_type;

   typedef struct packed {
      logic [0:0]   opcode;
      logic [7:0]   key_slot;
      logic [31:0]  time_value;
      logic signed [31:0] value_x;
      logic signed [31:0] value_y;
      logic signed [31:0] value_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic [7:0]         current_key;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [KEY_AW-1:0] addr;
      logic [31:0]       key_time;
      vec_type           key_vec;
   } wr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_CMP,
      ST_PAIR,
      ST_RDA,
      ST_RDB,
      ST_FSET,
      ST_DIV,
      ST_MUL,
      ST_ACC,
      ST_DONE
   } state_type;

endpackage

// File: hdl/kvs_key_store.sv
// Keyframe table: key times and key vectors in two synchronous memories.
// One write port, one registered read port. Depends on kvs_pkg.
`timescale 1ns / 1ps

module kvs_key_store (
   input  logic                       clock,
   input  kvs_pkg::wr_type            wr,
   input  logic [kvs_pkg::KEY_AW-1:0] rd_addr,
   output logic [31:0]                rd_time,
   output kvs_pkg::vec_type           rd_vec
);

   logic [31:0]      time_mem [kvs_pkg::MAX_KEYS];
   kvs_pkg::vec_type vec_mem  [kvs_pkg::MAX_KEYS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         time_mem[wr.addr] <= wr.key_time;
         vec_mem[wr.addr]  <= wr.key_vec;
      end
      rd_time <= time_mem[rd_addr];
      rd_vec  <= vec_mem[rd_addr];
   end

endmodule

// File: hdl/keyframe_vec3_sampler.sv
// Keyframe vec3 sampler top level: halving search over the key table, factor
// division, and shared-multiplier interpolation. Depends on kvs_pkg, kvs_key_store.
// Operation: a load beat writes the table when accepted and leaves busy low. A sample beat
//   keeps busy high through each search probe (memory read then compare, up to 9 probes
//   for 256 keys), the closing check, pair reads, factor setup, 16 division steps, 3
//   multiply/add pairs and the strobe; step and zero modes skip division and multiply.
// Throughput: one beat at a time; busy is high until the result strobe is gone.
// Reset: synchronous, resets control and config registers; table and datapath are kept.
`timescale 1ns / 1ps

module keyframe_vec3_sampler (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  kvs_pkg::req_type req,
   output logic             rsp_strobe,
   output kvs_pkg::rsp_type rsp,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data
);

   localparam int AW = kvs_pkg::KEY_AW;
   localparam int CW = kvs_pkg::CNT_W;

   kvs_pkg::state_type state_ff, state_in;

   logic [8:0]  key_count_ff;
   logic [31:0] duration_ff;
   logic [1:0]  mode_ff;

   logic [CW-1:0] n_ff, first_ff, first_in, count_ff, count_in;
   logic [31:0]   query_ff;
   logic [AW-1:0] cur_ff, nxt_ff, key_ff;
   logic [31:0]   a_time_ff, b_time_ff;
   kvs_pkg::vec_type a_vec_ff, b_vec_ff, res_ff;
   logic [32:0]   rem_ff, dur_ff;
   logic [16:0]   factor_ff;
   logic [3:0]    div_cnt_ff;
   logic [1:0]    comp_ff;
   logic signed [50:0] prod_ff;

   kvs_pkg::wr_type  wr;
   logic [AW-1:0]    rd_addr;
   logic [31:0]      rd_time;
   kvs_pkg::vec_type rd_vec;

   logic accept;
   logic [CW-1:0] half, probe, n_calc;
   logic [CW-1:0] ub, cur_c, nxt_c, step_c, cur_p1;
   logic          wrap;
   logic [31:0]   end_time;
   logic signed [33:0] dur_s, num_s;
   logic [32:0]   rem2;
   logic signed [31:0] comp_a, comp_b;
   logic signed [32:0] diff;
   logic signed [50:0] acc_sum;

   kvs_key_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_time (rd_time),
      .rd_vec  (rd_vec)
   );

   assign accept = start && (state_ff == kvs_pkg::ST_IDLE);

   always_comb begin
      wr.en       = accept && (req.opcode == kvs_pkg::OP_LOAD)
                    && (32'(req.key_slot) < kvs_pkg::MAX_KEYS);
      wr.addr     = AW'(req.key_slot);
      wr.key_time = req.time_value;
      wr.key_vec  = {req.value_z, req.value_y, req.value_x};
   end

   // clamp key count into 1..MAX_KEYS
   always_comb begin
      if (key_count_ff == 9'd0) begin
         n_calc = CW'(1);
      end else if (32'(key_count_ff) > kvs_pkg::MAX_KEYS) begin
         n_calc = CW'(kvs_pkg::MAX_KEYS);
      end else begin
         n_calc = CW'(key_count_ff);
      end
   end

   assign half  = count_ff >> 1;
   assign probe = first_ff + half;

   // pick start and next key from the upper bound
   always_comb begin
      ub     = first_ff;
      cur_c  = (ub == n_ff || ub == '0) ? n_ff - CW'(1) : ub - CW'(1);
      cur_p1 = cur_c + CW'(1);
      if (ub == n_ff) begin
         nxt_c = '0;
      end else begin
         nxt_c = (cur_p1 >= n_ff) ? '0 : cur_p1;
      end
      if (ub == n_ff) begin
         step_c = n_ff - CW'(1);
      end else if (ub == '0) begin
         step_c = '0;
      end else begin
         step_c = ub - CW'(1);
      end
   end

   always_comb begin
      wrap     = (nxt_ff == '0) && ({1'b0, cur_ff} == n_ff - CW'(1));
      end_time = wrap ? duration_ff : b_time_ff;
      dur_s    = $signed({2'b00, end_time}) - $signed({2'b00, a_time_ff});
      num_s    = $signed({2'b00, query_ff}) - $signed({2'b00, a_time_ff});
      rem2     = {rem_ff[31:0], 1'b0};
   end

   always_comb begin
      case (comp_ff)
         2'd0:    begin comp_a = a_vec_ff[0]; comp_b = b_vec_ff[0]; end
         2'd1:    begin comp_a = a_vec_ff[1]; comp_b = b_vec_ff[1]; end
         default: begin comp_a = a_vec_ff[2]; comp_b = b_vec_ff[2]; end
      endcase
      diff    = 33'(comp_b) - 33'(comp_a);
      acc_sum = 51'(comp_a) + (prod_ff >>> 16);
   end

   always_comb begin
      case (state_ff)
         kvs_pkg::ST_SEARCH: rd_addr = probe[AW-1:0];
         kvs_pkg::ST_PAIR:   rd_addr = (mode_ff == kvs_pkg::MODE_STEP) ?
                                       step_c[AW-1:0] : cur_c[AW-1:0];
         kvs_pkg::ST_RDA:    rd_addr = nxt_ff;
         default:            rd_addr = '0;
      endcase
   end

   always_comb begin
      first_in = first_ff;
      count_in = count_ff;
      if (accept) begin
         first_in = '0;
         count_in = n_calc;
      end else if (state_ff == kvs_pkg::ST_CMP) begin
         if (query_ff < rd_time) begin
            count_in = half;
         end else begin
            first_in = probe + CW'(1);
            count_in = count_ff - half - CW'(1);
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kvs_pkg::ST_IDLE: begin
            if (accept && req.opcode == kvs_pkg::OP_SAMPLE) state_in = kvs_pkg::ST_SEARCH;
         end
         kvs_pkg::ST_SEARCH: state_in = (count_ff == '0) ? kvs_pkg::ST_PAIR : kvs_pkg::ST_CMP;
         kvs_pkg::ST_CMP:    state_in = kvs_pkg::ST_SEARCH;
         kvs_pkg::ST_PAIR:   state_in = kvs_pkg::ST_RDA;
         kvs_pkg::ST_RDA:    state_in = kvs_pkg::ST_RDB;
         kvs_pkg::ST_RDB:    state_in = kvs_pkg::ST_FSET;
         kvs_pkg::ST_FSET: begin
            if (mode_ff != kvs_pkg::MODE_LINEAR) begin
               state_in = kvs_pkg::ST_DONE;
            end else if (dur_s > 0 && num_s > 0 && num_s < dur_s) begin
               state_in = kvs_pkg::ST_DIV;
            end else begin
               state_in = kvs_pkg::ST_MUL;
            end
         end
         kvs_pkg::ST_DIV:  state_in = (div_cnt_ff == 4'd0) ? kvs_pkg::ST_MUL : kvs_pkg::ST_DIV;
         kvs_pkg::ST_MUL:  state_in = kvs_pkg::ST_ACC;
         kvs_pkg::ST_ACC:  state_in = (comp_ff == 2'd2) ? kvs_pkg::ST_DONE : kvs_pkg::ST_MUL;
         kvs_pkg::ST_DONE: state_in = kvs_pkg::ST_IDLE;
         default:          state_in = kvs_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy            = (state_ff != kvs_pkg::ST_IDLE);
      rsp_strobe      = (state_ff == kvs_pkg::ST_DONE);
      rsp.out_x       = res_ff[0];
      rsp.out_y       = res_ff[1];
      rsp.out_z       = res_ff[2];
      rsp.current_key = 8'(key_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kvs_pkg::ST_IDLE;
         key_count_ff <= 9'd1;
         duration_ff  <= '0;
         mode_ff      <= kvs_pkg::MODE_LINEAR;
         first_ff     <= '0;
         count_ff     <= '0;
         n_ff         <= CW'(1);
         comp_ff      <= '0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
         count_ff <= count_in;
         if (csr_we) begin
            case (csr_index)
               kvs_pkg::REG_KEY_COUNT: key_count_ff <= csr_data[8:0];
               kvs_pkg::REG_DURATION:  duration_ff  <= csr_data;
               kvs_pkg::REG_MODE:      mode_ff      <= csr_data[1:0];
               default: ;
            endcase
         end
         if (accept) n_ff <= n_calc;
         if (state_ff == kvs_pkg::ST_FSET) begin
            comp_ff    <= '0;
            div_cnt_ff <= 4'd15;
         end else if (state_ff == kvs_pkg::ST_DIV) begin
            div_cnt_ff <= div_cnt_ff - 4'd1;
         end else if (state_ff == kvs_pkg::ST_ACC) begin
            comp_ff <= comp_ff + 2'd1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) query_ff <= req.time_value;
      case (state_ff)
         kvs_pkg::ST_PAIR: begin
            cur_ff <= cur_c[AW-1:0];
            nxt_ff <= nxt_c[AW-1:0];
            key_ff <= (mode_ff == kvs_pkg::MODE_STEP) ? step_c[AW-1:0] : cur_c[AW-1:0];
         end
         kvs_pkg::ST_RDA: begin
            a_time_ff <= rd_time;
            a_vec_ff  <= rd_vec;
         end
         kvs_pkg::ST_RDB: begin
            b_time_ff <= rd_time;
            b_vec_ff  <= rd_vec;
         end
         kvs_pkg::ST_FSET: begin
            rem_ff <= num_s[32:0];
            dur_ff <= dur_s[32:0];
            if (mode_ff == kvs_pkg::MODE_STEP) begin
               res_ff <= a_vec_ff;
            end else begin
               res_ff <= '0;
            end
            if (dur_s <= 0 || num_s <= 0) begin
               factor_ff <= '0;
            end else if (num_s >= dur_s) begin
               factor_ff <= kvs_pkg::FACTOR_ONE;
            end else begin
               factor_ff <= '0;
            end
         end
         kvs_pkg::ST_DIV: begin
            // restoring step: one quotient bit per cycle
            if (rem2 >= dur_ff) begin
               rem_ff    <= rem2 - dur_ff;
               factor_ff <= {factor_ff[15:0], 1'b1};
            end else begin
               rem_ff    <= rem2;
               factor_ff <= {factor_ff[15:0], 1'b0};
            end
         end
         kvs_pkg::ST_MUL: prod_ff <= diff * $signed({1'b0, factor_ff});
         kvs_pkg::ST_ACC: res_ff[comp_ff] <= acc_sum[31:0];
         default: ;
      endcase
   end

`ifndef SYNTH
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req.opcode == kvs_pkg::OP_SAMPLE) |=> busy)
      else $error("sample beat did not raise busy");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> (!busy && !rsp_strobe))
      else $error("result strobe not followed by idle");
   a_cmp_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kvs_pkg::ST_CMP) |-> (count_ff != '0))
      else $error("search compare with empty range");
   a_factor_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kvs_pkg::ST_MUL) |-> (factor_ff <= kvs_pkg::FACTOR_ONE))
      else $error("interpolation factor above one");
   a_ub_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kvs_pkg::ST_PAIR) |-> (first_ff <= n_ff))
      else $error("upper bound beyond key count");
`endif

endmodule

// File: verif/tb_top.sv
// Self-checking bench for keyframe_vec3_sampler: directed table, then random phases.
// Depends on kvs_pkg and the sampler RTL; holds its own track predictor.
`timescale 1ns / 1ps

module tb_top;

   typedef struct {
      bit               is_cfg;
      logic [1:0]       idx;
      logic [31:0]      data;
      kvs_pkg::req_type beat;
      bit               known;
      kvs_pkg::rsp_type want;
   } plan_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   kvs_pkg::req_type req = '0;
   logic    rsp_strobe;
   kvs_pkg::rsp_type rsp;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // predictor copy of the table and the registers
   logic [31:0]        key_time [kvs_pkg::MAX_KEYS];
   logic signed [31:0] key_val  [kvs_pkg::MAX_KEYS][3];
   logic [8:0]         reg_count;
   logic [31:0]        reg_span;
   logic [1:0]         reg_mode;

   kvs_pkg::rsp_type pending_samples [$];
   plan_row_type     plan [$];
   int errors = 0;
   int n_loads = 0;
   int n_samples = 0;
   int n_phases = 0;
   int n_full = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   keyframe_vec3_sampler dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_strobe(rsp_strobe), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   function automatic kvs_pkg::rsp_type sample_track(logic [31:0] q);
      int unsigned n, first, cnt, half, probe, ub, cur, nxt, key;
      longint t0, t1, span, num, fac, av, bv, res;
      logic signed [31:0] outv [3];
      kvs_pkg::rsp_type r;
      n = (reg_count == 0) ? 1 : (reg_count > kvs_pkg::MAX_KEYS) ? kvs_pkg::MAX_KEYS
                                                                   : reg_count;
      first = 0;
      cnt = n;
      while (cnt > 0) begin
         half = cnt / 2;
         probe = first + half;
         if (q < key_time[probe]) begin
            cnt = half;
         end else begin
            first = probe + 1;
            cnt = cnt - half - 1;
         end
      end
      ub = first;
      if (ub == n) begin
         cur = n - 1;
         nxt = 0;
      end else begin
         cur = (ub == 0) ? n - 1 : ub - 1;
         nxt = (cur + 1 >= n) ? 0 : cur + 1;
      end
      key = cur;
      for (int c = 0; c < 3; c++) outv[c] = '0;
      if (reg_mode == kvs_pkg::MODE_LINEAR) begin
         t0 = key_time[cur];
         t1 = key_time[nxt];
         // wrap span ends at the clip length
         if (nxt == 0 && cur == n - 1) t1 = reg_span;
         span = t1 - t0;
         fac = 0;
         if (span > 0) begin
            num = longint'(q) - t0;
            if (num <= 0) fac = 0;
            else if (num >= span) fac = 65536;
            else fac = (num * 65536) / span;
         end
         for (int c = 0; c < 3; c++) begin
            av = key_val[cur][c];
            bv = key_val[nxt][c];
            res = av + (((bv - av) * fac) >>> 16);
            outv[c] = res[31:0];
         end
      end else if (reg_mode == kvs_pkg::MODE_STEP) begin
         key = (ub == n) ? n - 1 : (ub == 0) ? 0 : ub - 1;
         for (int c = 0; c < 3; c++) outv[c] = key_val[key][c];
      end
      r.out_x = outv[0];
      r.out_y = outv[1];
      r.out_z = outv[2];
      r.current_key = key[7:0];
      return r;
   endfunction

   function automatic plan_row_type cfg_row(logic [1:0] idx, logic [31:0] data);
      plan_row_type p;
      p = '{default: '0};
      p.is_cfg = 1'b1;
      p.idx = idx;
      p.data = data;
      return p;
   endfunction

   function automatic plan_row_type load_row(logic [7:0] slot, logic [31:0] t,
                                              logic [31:0] x, logic [31:0] y,
                                              logic [31:0] z);
      plan_row_type p;
      p = '{default: '0};
      p.beat = '{kvs_pkg::OP_LOAD, slot, t, x, y, z};
      return p;
   endfunction

   function automatic plan_row_type smp_row(logic [31:0] q, bit known, logic [31:0] x,
                                             logic [31:0] y, logic [31:0] z,
                                             logic [7:0] k);
      plan_row_type p;
      p = '{default: '0};
      p.beat = '{kvs_pkg::OP_SAMPLE, 8'd0, q, 32'd0, 32'd0, 32'd0};
      p.known = known;
      p.want = '{x, y, z, k};
      return p;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 11))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   task automatic write_reg(logic [1:0] idx, logic [31:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         kvs_pkg::REG_KEY_COUNT: reg_count = data[8:0];
         kvs_pkg::REG_DURATION:  reg_span = data;
         kvs_pkg::REG_MODE:      reg_mode = data[1:0];
         default: ;
      endcase
   endtask

   // drain all expected samples, then let a trailing load finish
   task automatic wait_quiet();
      start <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic send_beat(kvs_pkg::req_type b, bit known, kvs_pkg::rsp_type want);
      int gap, r;
      r = $urandom_range(0, 99);
      gap = (r < 40) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req <= b;
      do @(posedge clock); while (busy);
      // beat accepted at this edge
      if (b.opcode == kvs_pkg::OP_LOAD) begin
         key_time[b.key_slot] = b.time_value;
         key_val[b.key_slot][0] = b.value_x;
         key_val[b.key_slot][1] = b.value_y;
         key_val[b.key_slot][2] = b.value_z;
         n_loads++;
      end else begin
         pending_samples.push_back(known ? want : sample_track(b.time_value));
         n_samples++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_samples.size() == 0) begin
            $error("result strobe with no sample pending");
            errors++;
         end else begin
            kvs_pkg::rsp_type w;
            w = pending_samples.pop_front();
            if (rsp.out_x !== w.out_x) begin
               $error("out_x expected %h got %h", w.out_x, rsp.out_x);
               errors++;
            end
            if (rsp.out_y !== w.out_y) begin
               $error("out_y expected %h got %h", w.out_y, rsp.out_y);
               errors++;
            end
            if (rsp.out_z !== w.out_z) begin
               $error("out_z expected %h got %h", w.out_z, rsp.out_z);
               errors++;
            end
            if (rsp.current_key !== w.current_key) begin
               $error("current_key expected %h got %h", w.current_key, rsp.current_key);
               errors++;
            end
         end
      end
   end

   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end

   initial begin
      int n, ph_items, r;
      logic [31:0] t, q;
      kvs_pkg::req_type b;
      kvs_pkg::rsp_type none;
      none = '0;
      reg_count = 9'd1;
      reg_span = '0;
      reg_mode = kvs_pkg::MODE_LINEAR;
      for (int i = 0; i < kvs_pkg::MAX_KEYS; i++) begin
         key_time[i] = '0;
         for (int c = 0; c < 3; c++) key_val[i][c] = '0;
      end

      // directed table
      plan.push_back(load_row(8'd0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0));
      plan.push_back(smp_row(32'h0, 1, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 8'd0));
      plan.push_back(smp_row(32'hffff_ffff, 1, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 8'd0));
      plan.push_back(load_row(8'd1, 32'h2_0000, 32'h8000_0000, 32'h7fff_ffff,
                              32'h1_0000));
      plan.push_back(cfg_row(kvs_pkg::REG_KEY_COUNT, 32'd2));
      plan.push_back(cfg_row(kvs_pkg::REG_DURATION, 32'h4_0000));
      plan.push_back(smp_row(32'h1_0000, 0, 0, 0, 0, 0));
      plan.push_back(smp_row(32'h3_0000, 0, 0, 0, 0, 0));
      plan.push_back(smp_row(32'hffff_ffff, 1, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 8'd1));
      plan.push_back(cfg_row(kvs_pkg::REG_DURATION, 32'h0));
      plan.push_back(smp_row(32'h3_0000, 1, 32'h8000_0000, 32'h7fff_ffff, 32'h1_0000, 8'd1));
      plan.push_back(cfg_row(kvs_pkg::REG_MODE, kvs_pkg::MODE_STEP));
      plan.push_back(smp_row(32'h1_0000, 1, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 8'd0));
      plan.push_back(smp_row(32'h2_0000, 1, 32'h8000_0000, 32'h7fff_ffff, 32'h1_0000, 8'd1));
      plan.push_back(cfg_row(kvs_pkg::REG_MODE, 32'd2));
      plan.push_back(smp_row(32'h1_0000, 1, 32'h0, 32'h0, 32'h0, 8'd0));
      plan.push_back(cfg_row(kvs_pkg::REG_MODE, 32'd3));
      plan.push_back(smp_row(32'h2_0000, 1, 32'h0, 32'h0, 32'h0, 8'd1));
      plan.push_back(cfg_row(kvs_pkg::REG_MODE, kvs_pkg::MODE_LINEAR));
      plan.push_back(cfg_row(kvs_pkg::REG_KEY_COUNT, 32'd0));
      plan.push_back(smp_row(32'h5, 1, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 8'd0));
      // query below key 0 wraps back to the last key
      plan.push_back(cfg_row(kvs_pkg::REG_KEY_COUNT, 32'd2));
      plan.push_back(cfg_row(kvs_pkg::REG_DURATION, 32'h8_0000));
      plan.push_back(load_row(8'd0, 32'h1_0000, 32'd1, 32'd2, 32'd3));
      plan.push_back(smp_row(32'h0, 1, 32'h8000_0000, 32'h7fff_ffff, 32'h1_0000, 8'd1));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            wait_quiet();
            write_reg(plan[i].idx, plan[i].data);
         end else begin
            send_beat(plan[i].beat, plan[i].known, plan[i].want);
         end
      end

      // random phases: fill the used slots, configure, then mix samples and loads
      while (n_loads + n_samples < 1950) begin
         r = $urandom_range(0, 99);
         if (r < 3 && n_full < 2) begin
            n = kvs_pkg::MAX_KEYS;
            n_full++;
         end else if (r < 15) begin
            n = $urandom_range(9, 40);
         end else begin
            n = $urandom_range(1, 8);
         end
         t = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom_range(0, 32'h10_0000);
         for (int i = 0; i < n; i++) begin
            b.opcode = kvs_pkg::OP_LOAD;
            b.key_slot = 8'(i);
            b.time_value = ($urandom_range(0, 9) == 0) ? $urandom() : t;
            b.value_x = rand_word();
            b.value_y = rand_word();
            b.value_z = rand_word();
            send_beat(b, 0, none);
            // hold repeats now and then for equal key times
            if ($urandom_range(0, 7) != 0) t = t + $urandom_range(1, 32'h4_0000);
         end
         wait_quiet();
         if (n == 1 && $urandom_range(0, 2) == 0) write_reg(kvs_pkg::REG_KEY_COUNT, 32'd0);
         else if (n == kvs_pkg::MAX_KEYS && $urandom_range(0, 1) == 0)
            write_reg(kvs_pkg::REG_KEY_COUNT, 32'd511);
         else write_reg(kvs_pkg::REG_KEY_COUNT, n);
         case ($urandom_range(0, 4))
            0: write_reg(kvs_pkg::REG_DURATION, 32'h0);
            1: write_reg(kvs_pkg::REG_DURATION, 32'hffff_ffff);
            2: write_reg(kvs_pkg::REG_DURATION, $urandom());
            default: write_reg(kvs_pkg::REG_DURATION, t + $urandom_range(0, 32'h4_0000));
         endcase
         r = $urandom_range(0, 9);
         write_reg(kvs_pkg::REG_MODE, (r < 5) ? kvs_pkg::MODE_LINEAR :
                                      (r < 8) ? kvs_pkg::MODE_STEP : r - 6);
         n_phases++;
         ph_items = $urandom_range(20, 40);
         for (int i = 0; i < ph_items; i++) begin
            if ($urandom_range(0, 4) == 0) begin
               b.opcode = kvs_pkg::OP_LOAD;
               b.key_slot = 8'($urandom_range(0, 255));
               b.time_value = rand_word();
               b.value_x = rand_word();
               b.value_y = rand_word();
               b.value_z = rand_word();
            end else begin
               case ($urandom_range(0, 9))
                  0: q = rand_word();
                  1: q = key_time[$urandom_range(0, n - 1)];
                  default: q = key_time[$urandom_range(0, n - 1)] +
                               $urandom_range(0, 32'h4_0000) - 32'h1_0000;
               endcase
               b = '0;
               b.opcode = kvs_pkg::OP_SAMPLE;
               b.key_slot = 8'($urandom());
               b.time_value = q;
               b.value_x = $urandom();
               b.value_y = $urandom();
               b.value_z = $urandom();
            end
            send_beat(b, 0, none);
         end
         wait_quiet();
      end

      wait_quiet();
      $display("Covered %0d loads and %0d samples over %0d random phases", n_loads,
               n_samples, n_phases);
      $display("Modes linear, step and zero; key counts 0 to 511; %0d mismatches", errors);
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
